// ===== sv/sbq_pkg.sv =====
// ----------------------------------------------------------------------------
// sbq_pkg
// shared types and constants of the stereo biquad cascade
// ----------------------------------------------------------------------------
package sbq_pkg;

  localparam int DEF_FRAC_BITS  = 16;
  localparam int DEF_PASS_COUNT = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LP_GAIN_A1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LP_FB_B1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LP_FB_B2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HP_GAIN_A1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HP_FB_B1  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HP_FB_B2  = 3'd7;

  localparam logic [7:0] VOLUME_RESET = 8'd128;

  // filter mode codes
  localparam logic [1:0] MODE_LP = 2'd0;
  localparam logic [1:0] MODE_HP = 2'd1;
  localparam logic [1:0] MODE_BP = 2'd2;

  // one history entry of a section
  typedef struct packed {
    logic [63:0] in1;
    logic [63:0] in2;
    logic [63:0] out1;
    logic [63:0] out2;
  } hist_t;

endpackage

// ===== sv/stereo_biquad_cascade.sv =====
// ----------------------------------------------------------------------------
// stereo_biquad_cascade
// volume scaling and a per-channel cascade of direct form i biquad sections
// ----------------------------------------------------------------------------
// One sample is taken at a time. It is scaled by volume in the cycle it is
// accepted, then each biquad section runs one history read, ten issues of the
// shared 33x33 multiplier (each of the five taps is a 64-bit product formed
// from two halves), the drain states D1 and D2 for the product and accumulate
// stages, and one write-back. A pass has one section, two in bandpass mode.
// Section histories live in one memory of 4 * PASS_COUNT entries; per-entry
// valid bits make unwritten entries read as zero after reset, so no clearing
// pass is needed. The result register frees the input side as soon as a
// result is loaded.
// ----------------------------------------------------------------------------
module stereo_biquad_cascade
  import sbq_pkg::*;
#(
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int PASS_COUNT = DEF_PASS_COUNT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    in_sample_in,
  input  logic                  in_channel_sel,
  input  logic                  in_buffer_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    out_sample_out,
  output logic                  out_clipped,
  output logic                  out_channel_out,
  output logic                  out_buffer_end_out,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SHIFT_S = FRAC_BITS - 13;
  localparam int DEPTH   = 4 * PASS_COUNT;
  localparam int AW      = $clog2(DEPTH);
  localparam int PW      = (PASS_COUNT > 1) ? $clog2(PASS_COUNT) : 1;
  localparam logic [PW-1:0] PASS_LAST = PW'(PASS_COUNT - 1);
  localparam logic [3:0]    STEP_LAST = 4'd9;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_MUL, S_D1, S_D2, S_WB, S_FIN
  } state_t;

  // configuration
  logic [7:0]  volume_r;
  logic [1:0]  mode_r;
  logic [31:0] lp_a1_r, lp_b1_r, lp_b2_r, hp_a1_r, hp_b1_r, hp_b2_r;

  // control
  state_t          state_r;
  logic [PW-1:0]   pass_r;
  logic            sub_r;
  logic [3:0]      k_r;
  logic            pv_r;
  logic [3:0]      pk_r;
  logic            tv_v_r;
  logic [2:0]      tt_r;
  logic            ch_r, be_r;
  logic [DEPTH-1:0] hist_vld_r;

  // datapath
  logic [31:0] cur_r;
  logic [63:0] xs_r;
  logic [63:0] prod_r, lo_r, tv_r, acc_r;
  hist_t       rd_q_r;
  logic        vld_q_r;
  hist_t       hist_mem [DEPTH];

  logic               accept;
  logic               hp_sel;
  logic [AW-1:0]      idx;
  hist_t              hist_in, wb_entry;
  logic [31:0]        coef;
  logic [63:0]        dsel;
  logic [2:0]         k_term, p_term;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [24:0] vol_p;
  logic [63:0]        term_sum, term_dbl, term_adj;
  logic signed [63:0] tv_shr, y_shr;
  logic [63:0]        acc_nxt;
  logic               last_sec;
  logic               out_free;
  logic signed [15:0] sat_val;
  logic               sat_clip;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    unique case (mode_r)
      MODE_HP: hp_sel = 1'b1;
      MODE_BP: hp_sel = sub_r;
      default: hp_sel = 1'b0;
    endcase
  end

  assign idx = AW'(AW'({hp_sel, ch_r}) * AW'(PASS_COUNT) + AW'(pass_r));
  assign last_sec = ((mode_r != MODE_BP) || sub_r) && (pass_r == PASS_LAST);

  assign hist_in = vld_q_r ? rd_q_r : '0;

  // operand selection for the shared multiplier
  assign k_term = k_r[3:1];
  always_comb begin
    unique case (k_term)
      3'd0: begin
        coef = hp_sel ? hp_a1_r : lp_a1_r;
        dsel = xs_r;
      end
      3'd1: begin
        coef = hp_sel ? hp_a1_r : lp_a1_r;
        dsel = hist_in.in1;
      end
      3'd2: begin
        coef = hp_sel ? hp_a1_r : lp_a1_r;
        dsel = hist_in.in2;
      end
      3'd3: begin
        coef = hp_sel ? hp_b1_r : lp_b1_r;
        dsel = hist_in.out1;
      end
      3'd4: begin
        coef = hp_sel ? hp_b2_r : lp_b2_r;
        dsel = hist_in.out2;
      end
      default: begin
        coef = '0;
        dsel = '0;
      end
    endcase
  end

  assign mul_a = {coef[31], coef};
  assign mul_b = k_r[0] ? {1'b0, dsel[63:32]} : {1'b0, dsel[31:0]};
  assign mul_p = mul_a * mul_b;

  // low and high halves combine into the 64-bit wrapped product
  assign p_term   = pk_r[3:1];
  assign term_sum = {lo_r[63:32] + prod_r[31:0], lo_r[31:0]};
  assign term_dbl = {term_sum[62:0], 1'b0};
  always_comb begin
    if (p_term == 3'd1) begin
      term_adj = hp_sel ? (64'd0 - term_dbl) : term_dbl;
    end else begin
      term_adj = term_sum;
    end
  end

  assign tv_shr  = $signed(tv_r) >>> FRAC_BITS;
  assign acc_nxt = (tt_r == 3'd3 || tt_r == 3'd4) ? (acc_r - tv_shr) : (acc_r + tv_shr);

  assign y_shr = $signed(acc_r) >>> SHIFT_S;

  assign wb_entry = '{in1: xs_r, in2: hist_in.in1, out1: acc_r, out2: hist_in.out1};

  assign vol_p = in_sample_in * $signed({1'b0, volume_r});

  always_comb begin
    if ($signed(cur_r) > 32'sd32767) begin
      sat_val  = 16'sh7fff;
      sat_clip = 1'b1;
    end else if ($signed(cur_r) < -32'sd32768) begin
      sat_val  = 16'sh8000;
      sat_clip = 1'b1;
    end else begin
      sat_val  = cur_r[15:0];
      sat_clip = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= VOLUME_RESET;
      mode_r   <= MODE_LP;
      lp_a1_r  <= '0;
      lp_b1_r  <= '0;
      lp_b2_r  <= '0;
      hp_a1_r  <= '0;
      hp_b1_r  <= '0;
      hp_b2_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_VOLUME:     volume_r <= cfg_data[7:0];
        REG_MODE:       mode_r   <= cfg_data[1:0];
        REG_LP_GAIN_A1: lp_a1_r  <= cfg_data;
        REG_LP_FB_B1:   lp_b1_r  <= cfg_data;
        REG_LP_FB_B2:   lp_b2_r  <= cfg_data;
        REG_HP_GAIN_A1: hp_a1_r  <= cfg_data;
        REG_HP_FB_B1:   hp_b1_r  <= cfg_data;
        REG_HP_FB_B2:   hp_b2_r  <= cfg_data;
      endcase
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      pass_r             <= '0;
      sub_r              <= 1'b0;
      k_r                <= '0;
      pv_r               <= 1'b0;
      pk_r               <= '0;
      tv_v_r             <= 1'b0;
      tt_r               <= '0;
      hist_vld_r         <= '0;
      out_valid          <= 1'b0;
      out_sample_out     <= '0;
      out_clipped        <= 1'b0;
      out_channel_out    <= 1'b0;
      out_buffer_end_out <= 1'b0;
    end else begin
      pv_r   <= (state_r == S_MUL);
      pk_r   <= k_r;
      tv_v_r <= pv_r && pk_r[0];
      tt_r   <= p_term;
      if (state_r == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            pass_r  <= '0;
            sub_r   <= 1'b0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          k_r     <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          k_r <= k_r + 4'd1;
          if (k_r == STEP_LAST) begin
            state_r <= S_D1;
          end
        end
        S_D1: state_r <= S_D2;
        S_D2: state_r <= S_WB;
        S_WB: begin
          hist_vld_r[idx] <= 1'b1;
          if (last_sec) begin
            state_r <= S_FIN;
          end else begin
            if (mode_r == MODE_BP && !sub_r) begin
              sub_r <= 1'b1;
            end else begin
              sub_r  <= 1'b0;
              pass_r <= pass_r + PW'(1);
            end
            state_r <= S_RD;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_sample_out     <= sat_val;
            out_clipped        <= sat_clip;
            out_channel_out    <= ch_r;
            out_buffer_end_out <= be_r;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r <= 32'($signed(vol_p[24:8]));
      ch_r  <= in_channel_sel;
      be_r  <= in_buffer_end;
    end else if (state_r == S_WB) begin
      cur_r <= y_shr[31:0];
    end
    if (state_r == S_RD) begin
      xs_r  <= {{32{cur_r[31]}}, cur_r} << SHIFT_S;
      acc_r <= '0;
    end else if (tv_v_r) begin
      acc_r <= acc_nxt;
    end
    prod_r <= mul_p[63:0];
    if (pv_r) begin
      if (pk_r[0]) begin
        tv_r <= term_adj;
      end else begin
        lo_r <= prod_r;
      end
    end
  end

  // history memory
  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      rd_q_r  <= hist_mem[idx];
      vld_q_r <= hist_vld_r[idx];
    end
    if (state_r == S_WB) begin
      hist_mem[idx] <= wb_entry;
    end
  end

endmodule
